[rtl/bsc_pkg.sv]
// Shared types and constants for the safety-check block.
package bsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 8;

  localparam int FUNC_W    = 2;
  localparam int PIDX_W    = 4;
  localparam int RIDX_W    = 3;
  localparam int SEQ_W     = 4;
  localparam int PC_W      = 5;
  localparam int RC_W      = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_AVAIL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'b1;

  localparam logic KIND_SEQ     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic init;
    logic test_start;
    logic grant;
    logic miss;
    logic emit_seq;
    logic emit_ver;
  } bsc_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic cur_done;
    logic eval_done;
    logic eval_fit;
    logic all_granted;
    logic out_free;
    logic emit_last;
  } bsc_sts_t;

endpackage

[rtl/bsc_if.sv]
// Input and result channel interfaces of the safety-check block.
interface bsc_in_if #(
  parameter int AMOUNT_BITS = 12
);
  import bsc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [PIDX_W-1:0]      process_index;
  logic [RIDX_W-1:0]      resource_index;
  logic [AMOUNT_BITS-1:0] avail_amount;
  logic [AMOUNT_BITS-1:0] max_amount;
  logic [AMOUNT_BITS-1:0] held_amount;

  modport source (
    output valid, func, process_index, resource_index, avail_amount, max_amount,
           held_amount,
    input  ready
  );
  modport sink (
    input  valid, func, process_index, resource_index, avail_amount, max_amount,
           held_amount,
    output ready
  );
endinterface

interface bsc_out_if;
  import bsc_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SEQ_W-1:0] seq_process;
  logic             safe;
  logic             last;

  modport source (output valid, kind, seq_process, safe, last, input ready);
  modport sink (input valid, kind, seq_process, safe, last, output ready);
endinterface

[rtl/bankers_safety_check_top.sv]
// Top level of the resource safety-check block.
// Usage: in_if carries one word per item. func FUNC_AVAIL loads the free units of
// one resource, FUNC_ENTRY loads max and held units of one process/resource pair,
// FUNC_CHECK starts a safety scan. Every table entry in use is loaded before a check.
// cfg_we/cfg_index/cfg_wdata set process_count (index 0) and resource_count
// (index 1), both reset to 1; the user writes them only while the block is idle,
// which the block itself does not enforce. A new word is accepted every cycle while
// no check runs. A check runs a setup step, then visits processes in turn: one that
// already finished is skipped, otherwise its resources are tested against the work
// vector, bounded by the single read port of the need/held memory, which yields one
// resource per cycle, and a grant step follows when all fit. The scan ends after a
// full pass without a grant; then out_if delivers the safe sequence (one word per
// process) if every process was granted, and a verdict word with last set, one word
// per cycle while out_if.ready allows. No input is accepted from a check until its
// verdict is in the output register, which lets loads and the next scan proceed
// while a verdict waits. When out_if.ready is low the pending word holds and
// emission stalls. Synchronous reset clears the sequencer, the counters and the
// output valid; the tables hold no reset value and need no clearing pass.
module bankers_safety_check_top #(
  parameter int AMOUNT_BITS   = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]     cfg_wdata,
  bsc_in_if.sink                        in_if,
  bsc_out_if.source                     out_if
);
  import bsc_pkg::*;

  bsc_cmd_t cmd;
  bsc_sts_t sts;
  logic     in_fire;

  assign in_fire = in_if.valid && in_if.ready;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsc_dp #(
    .AMOUNT_BITS   (AMOUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_fire           (in_fire),
    .in_func           (in_if.func),
    .in_process_index  (in_if.process_index),
    .in_resource_index (in_if.resource_index),
    .in_avail_amount   (in_if.avail_amount),
    .in_max_amount     (in_if.max_amount),
    .in_held_amount    (in_if.held_amount),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_kind          (out_if.kind),
    .out_seq_process   (out_if.seq_process),
    .out_safe          (out_if.safe),
    .out_last          (out_if.last)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init, cmd.test_start, cmd.grant, cmd.miss, cmd.emit_seq, cmd.emit_ver}))
    else $error("sequencer issued more than one command");

  a_grant_after_fit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |-> $past(sts.eval_done && sts.eval_fit))
    else $error("grant without a fitting evaluation");

  a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_seq || cmd.emit_ver) |-> !in_if.ready)
    else $error("input accepted during result emission");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ver |=> out_if.valid && out_if.last && (out_if.kind == KIND_VERDICT))
    else $error("verdict word not presented");

endmodule

[rtl/bsc_ctrl.sv]
// Sequencer for table loads, the safety scan and result emission.
module bsc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [bsc_pkg::FUNC_W-1:0]   in_func,
  output logic                         in_ready,
  input  bsc_pkg::bsc_sts_t            sts,
  output bsc_pkg::bsc_cmd_t            cmd
);
  import bsc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_INIT     = 7'b0000010,
    ST_SCAN     = 7'b0000100,
    ST_TEST     = 7'b0001000,
    ST_GRANT    = 7'b0010000,
    ST_EMIT_SEQ = 7'b0100000,
    ST_EMIT_VER = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_func == FUNC_CHECK)) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = sts.all_granted ? ST_EMIT_SEQ : ST_EMIT_VER;
        end else if (sts.cur_done) begin
          cmd.miss = 1'b1;
        end else begin
          cmd.test_start = 1'b1;
          state_nxt      = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.eval_done) begin
          if (sts.eval_fit) begin
            state_nxt = ST_GRANT;
          end else begin
            cmd.miss  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_EMIT_SEQ: begin
        if (sts.out_free) begin
          cmd.emit_seq = 1'b1;
          if (sts.emit_last) state_nxt = ST_EMIT_VER;
        end
      end
      ST_EMIT_VER: begin
        if (sts.out_free) begin
          cmd.emit_ver = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/bsc_dp.sv]
// Tables, work vector, scan counters and output register of the safety check.
module bsc_dp #(
  parameter int AMOUNT_BITS   = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_fire,
  input  logic [bsc_pkg::FUNC_W-1:0]      in_func,
  input  logic [bsc_pkg::PIDX_W-1:0]      in_process_index,
  input  logic [bsc_pkg::RIDX_W-1:0]      in_resource_index,
  input  logic [AMOUNT_BITS-1:0]          in_avail_amount,
  input  logic [AMOUNT_BITS-1:0]          in_max_amount,
  input  logic [AMOUNT_BITS-1:0]          in_held_amount,
  input  bsc_pkg::bsc_cmd_t               cmd,
  output bsc_pkg::bsc_sts_t               sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic [bsc_pkg::SEQ_W-1:0]       out_seq_process,
  output logic                            out_safe,
  output logic                            out_last
);
  import bsc_pkg::*;

  localparam int PW     = $clog2(MAX_PROCESSES);
  localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NP_W   = $clog2(MAX_PROCESSES + 1);
  localparam int NR_W   = $clog2(MAX_RESOURCES + 1);
  localparam int AW     = $clog2(MAX_PROCESSES * MAX_RESOURCES);
  localparam int NEED_W = AMOUNT_BITS + 1;
  localparam int WORK_W = AMOUNT_BITS + $clog2(MAX_PROCESSES + 1);
  localparam int MEM_W  = NEED_W + AMOUNT_BITS;

  // configuration
  logic [PC_W-1:0] pc_r;
  logic [RC_W-1:0] rc_r;
  logic [NP_W-1:0] np;
  logic [NR_W-1:0] nr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_W'(1);
      rc_r <= RC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_COUNT:  pc_r <= cfg_wdata[PC_W-1:0];
        REG_RESOURCE_COUNT: rc_r <= cfg_wdata[RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pc_r == '0)                    np = NP_W'(1);
    else if (32'(pc_r) > MAX_PROCESSES) np = NP_W'(MAX_PROCESSES);
    else                               np = NP_W'(pc_r);
    if (rc_r == '0)                    nr = NR_W'(1);
    else if (32'(rc_r) > MAX_RESOURCES) nr = NR_W'(MAX_RESOURCES);
    else                               nr = NR_W'(rc_r);
  end

  // table loads
  logic              p_ok, r_ok, ld_avail, ld_entry;
  logic [NEED_W-1:0] need_w;
  logic [AW-1:0]     wr_addr, rd_addr;

  assign p_ok     = 32'(in_process_index) < MAX_PROCESSES;
  assign r_ok     = 32'(in_resource_index) < MAX_RESOURCES;
  assign ld_avail = in_fire && (in_func == FUNC_AVAIL) && r_ok;
  assign ld_entry = in_fire && (in_func == FUNC_ENTRY) && p_ok && r_ok;
  assign need_w   = {1'b0, in_max_amount} - {1'b0, in_held_amount};
  assign wr_addr  = AW'(in_process_index) * AW'(MAX_RESOURCES) + AW'(in_resource_index);

  logic [AMOUNT_BITS-1:0] avail_r [MAX_RESOURCES];
  logic [MEM_W-1:0]       entry_mem_r [MAX_PROCESSES * MAX_RESOURCES];
  logic [MEM_W-1:0]       rd_q_r;

  // scan state
  logic [PW-1:0]     scan_ptr_r, ptr_adv;
  logic [NP_W-1:0]   miss_cnt_r, granted_r;
  logic [MAX_PROCESSES-1:0] done_r;
  logic              iss_act_r, rd_v_r, fit_r;
  logic [RW-1:0]     iss_idx_r, rd_idx_r;
  logic [PW-1:0]     k_r;
  logic [WORK_W-1:0] work_r [MAX_RESOURCES];
  logic [WORK_W-1:0] tmp_r  [MAX_RESOURCES];
  logic [PW-1:0]     order_r [MAX_PROCESSES];

  logic                  iss_last, rd_last, fit_now;
  logic [NEED_W-1:0]     need_q;
  logic [AMOUNT_BITS-1:0] held_q;
  logic signed [WORK_W:0] need_ext, work_ext;

  assign rd_addr  = AW'(scan_ptr_r) * AW'(MAX_RESOURCES) + AW'(iss_idx_r);
  assign iss_last = (NR_W'(iss_idx_r) + NR_W'(1)) == nr;
  assign rd_last  = rd_v_r && ((NR_W'(rd_idx_r) + NR_W'(1)) == nr);
  assign ptr_adv  = ((NP_W'(scan_ptr_r) + NP_W'(1)) == np) ? '0 : scan_ptr_r + PW'(1);
  assign need_q   = rd_q_r[MEM_W-1 -: NEED_W];
  assign held_q   = rd_q_r[AMOUNT_BITS-1:0];
  assign need_ext = {{(WORK_W + 1 - NEED_W){need_q[NEED_W-1]}}, need_q};
  assign work_ext = {1'b0, work_r[rd_idx_r]};
  assign fit_now  = need_ext <= work_ext;

  always_ff @(posedge clk) begin
    if (ld_avail) avail_r[RW'(in_resource_index)] <= in_avail_amount;
    if (ld_entry) entry_mem_r[wr_addr] <= {need_w, in_held_amount};
    if (iss_act_r) rd_q_r <= entry_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r  <= '0;
      miss_cnt_r  <= '0;
      granted_r   <= '0;
      done_r      <= '0;
      iss_act_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      k_r         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.init) begin
        scan_ptr_r <= '0;
        miss_cnt_r <= '0;
        granted_r  <= '0;
        done_r     <= '0;
        k_r        <= '0;
      end
      if (cmd.miss) begin
        miss_cnt_r <= miss_cnt_r + NP_W'(1);
        scan_ptr_r <= ptr_adv;
      end
      if (cmd.grant) begin
        done_r[scan_ptr_r] <= 1'b1;
        granted_r          <= granted_r + NP_W'(1);
        miss_cnt_r         <= '0;
        scan_ptr_r         <= ptr_adv;
      end
      if (cmd.test_start)           iss_act_r <= 1'b1;
      else if (iss_act_r && iss_last) iss_act_r <= 1'b0;
      rd_v_r <= iss_act_r;
      if (cmd.emit_seq) k_r <= k_r + PW'(1);
      if (cmd.emit_seq || cmd.emit_ver) out_valid <= 1'b1;
      else if (out_ready)               out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < MAX_RESOURCES; i++) work_r[i] <= WORK_W'(avail_r[i]);
    end else if (cmd.grant) begin
      for (int i = 0; i < MAX_RESOURCES; i++) work_r[i] <= tmp_r[i];
    end
    if (cmd.test_start) begin
      iss_idx_r <= '0;
      fit_r     <= 1'b1;
    end else begin
      if (iss_act_r) iss_idx_r <= iss_idx_r + RW'(1);
      if (rd_v_r)    fit_r     <= fit_r & fit_now;
    end
    if (iss_act_r) rd_idx_r <= iss_idx_r;
    if (rd_v_r) tmp_r[rd_idx_r] <= work_r[rd_idx_r] + WORK_W'(held_q);
    if (cmd.grant) order_r[granted_r[PW-1:0]] <= scan_ptr_r;
    if (cmd.emit_seq) begin
      out_kind        <= KIND_SEQ;
      out_seq_process <= SEQ_W'(order_r[k_r]);
      out_safe        <= 1'b0;
      out_last        <= 1'b0;
    end else if (cmd.emit_ver) begin
      out_kind        <= KIND_VERDICT;
      out_seq_process <= '0;
      out_safe        <= sts.all_granted;
      out_last        <= 1'b1;
    end
  end

  always_comb begin
    sts.scan_end    = miss_cnt_r >= np;
    sts.cur_done    = done_r[scan_ptr_r];
    sts.eval_done   = rd_last;
    sts.eval_fit    = fit_r && fit_now;
    sts.all_granted = granted_r == np;
    sts.out_free    = !out_valid || out_ready;
    sts.emit_last   = (NP_W'(k_r) + NP_W'(1)) == np;
  end

endmodule
